// ----- src/pli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types, codes and defaults for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DEF_MAX_POINTS = 64;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_FEW  = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;

  // restoring divider: 65-bit dividend, one quotient bit per step,
  // preceded by one rounding step
  localparam int DIV_STEPS = 65;
  localparam int DIV_CW    = 7;

  typedef struct packed {
    logic load;
    logic ins_rd;
    logic ins_cmp;
    logic ins_put;
    logic bs_rd;
    logic bs_cmp;
    logic seg_j;
    logic seg_rd0;
    logic seg_rd1;
    logic seg_ld;
    logic set_zero;
    logic mul0;
    logic mul1;
    logic div_init;
    logic div_step;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic few;
    logic empty;
    logic gt;
    logic idx_zero;
    logic bs_done;
    logic dx_bad;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ----- src/pli_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for clear, insert and evaluate requests.
// ----------------------------------------------------------------------------
module pli_ctrl import pli_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_INS_RD   = 16'h0002,
    S_INS_CMP  = 16'h0004,
    S_INS_PUT  = 16'h0008,
    S_BS_RD    = 16'h0010,
    S_BS_CMP   = 16'h0020,
    S_SEG_J    = 16'h0040,
    S_SEG_RD0  = 16'h0080,
    S_SEG_RD1  = 16'h0100,
    S_SEG_LD   = 16'h0200,
    S_CHK      = 16'h0400,
    S_MUL0     = 16'h0800,
    S_MUL1     = 16'h1000,
    S_DIV_INIT = 16'h2000,
    S_DIV      = 16'h4000,
    S_OUT      = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   fin_pending;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          case (req_type)
            REQ_INSERT: begin
              if (sts.full)       state_next = S_OUT;
              else if (sts.empty) state_next = S_INS_PUT;
              else                state_next = S_INS_RD;
            end
            REQ_EVAL: state_next = sts.few ? S_OUT : S_BS_RD;
            default:  state_next = S_OUT;
          endcase
        end
      end
      S_INS_RD: begin
        cmd.ins_rd = 1'b1;
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd.ins_cmp = 1'b1;
        if (!sts.gt)          state_next = S_OUT;
        else if (sts.idx_zero) state_next = S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_next  = S_OUT;
      end
      S_BS_RD: begin
        cmd.bs_rd  = 1'b1;
        state_next = sts.bs_done ? S_SEG_J : S_BS_CMP;
      end
      S_BS_CMP: begin
        cmd.bs_cmp = 1'b1;
        state_next = S_BS_RD;
      end
      S_SEG_J: begin
        cmd.seg_j  = 1'b1;
        state_next = S_SEG_RD0;
      end
      S_SEG_RD0: begin
        cmd.seg_rd0 = 1'b1;
        state_next  = S_SEG_RD1;
      end
      S_SEG_RD1: begin
        cmd.seg_rd1 = 1'b1;
        state_next  = S_SEG_LD;
      end
      S_SEG_LD: begin
        cmd.seg_ld = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.dx_bad) begin
          cmd.set_zero = 1'b1;
          state_next   = S_OUT;
        end else begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.fin = fin_pending;
        if (sts.out_free && !fin_pending) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // final add and saturation run in the cycle after the last divide step
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fin_pending <= 1'b0;
    end else begin
      state       <= state_next;
      fin_pending <= (state == S_DIV) && sts.div_last;
    end
  end

endmodule

// ----- src/pli_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_datapath
// Breakpoint memories, search registers, multiplier, divider and result word.
// ----------------------------------------------------------------------------
module pli_datapath import pli_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value_y,
  output logic [2:0]         status,
  output logic signed [31:0] lowest_x,
  output logic signed [31:0] highest_x,
  output logic [CW-1:0]      points_held
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

  logic [31:0] ax_mem [MAX_POINTS];
  logic [31:0] oy_mem [MAX_POINTS];
  logic signed [31:0] rd_x, rd_y;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_x, wr_y;

  logic [CW-1:0] count;
  logic signed [31:0] px, py, qx, lo_x, hi_x, y0, x0;
  logic [AW-1:0] idx, j;
  logic [CW-1:0] bs_lo, bs_hi;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] jk, jm;
  logic signed [32:0] dx, dy, dq;
  logic [32:0]   ady, adq;
  logic          neg;
  logic [64:0]   prod;
  logic [64:0]   num;
  logic [31:0]   rem, dxu;
  logic [32:0]   sh;
  logic [DIV_CW-1:0] div_cnt;
  logic [34:0]   qc;
  logic signed [36:0] res;
  logic signed [31:0] res_value;
  logic [2:0]    res_status;
  logic          gt, commit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ax_mem[wr_addr] <= wr_x;
      oy_mem[wr_addr] <= wr_y;
    end
    rd_x <= ax_mem[rd_addr];
    rd_y <= oy_mem[rd_addr];
  end

  assign mid_sum = {1'b0, bs_lo} + {1'b0, bs_hi};
  assign mid     = mid_sum[CW:1];
  assign jk      = (bs_lo == '0) ? '0 : bs_lo - 1'b1;
  assign jm      = count - CW'(2);

  always_comb begin
    rd_addr = idx;
    if (cmd.ins_cmp)      rd_addr = idx - 1'b1;
    else if (cmd.bs_rd)   rd_addr = mid[AW-1:0];
    else if (cmd.seg_rd0) rd_addr = j;
    else if (cmd.seg_rd1) rd_addr = j + 1'b1;
  end

  // stored entry sorts after the new point
  assign gt = (rd_x > px) || ((rd_x == px) && (rd_y > py));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx + 1'b1;
    wr_x    = px;
    wr_y    = py;
    commit  = 1'b0;
    if (cmd.ins_cmp) begin
      wr_en = 1'b1;
      if (gt) begin
        wr_x = rd_x;
        wr_y = rd_y;
      end else begin
        commit = 1'b1;
      end
    end else if (cmd.ins_put) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      commit  = 1'b1;
    end
  end

  assign sh  = {rem, num[64]};
  assign qc  = (num > 65'h400000000) ? 35'h400000000 : num[34:0];
  assign res = neg ? (37'(y0) - $signed({2'b00, qc})) : (37'(y0) + $signed({2'b00, qc}));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px         <= point_x;
      py         <= point_y;
      qx         <= query_x;
      idx        <= AW'(count - 1'b1);
      bs_lo      <= '0;
      bs_hi      <= count;
      res_value  <= '0;
      res_status <= ST_OK;
      if (req_type == REQ_INSERT && count == MAXC) res_status <= ST_FULL;
      if (req_type == REQ_EVAL && count < CW'(2))  res_status <= ST_FEW;
    end
    if (cmd.ins_cmp && gt) idx <= idx - 1'b1;
    if (cmd.bs_cmp) begin
      if (rd_x < qx) bs_lo <= mid + 1'b1;
      else           bs_hi <= mid;
    end
    if (cmd.seg_j) j <= (jk > jm) ? jm[AW-1:0] : jk[AW-1:0];
    if (cmd.seg_rd1) begin
      x0 <= rd_x;
      y0 <= rd_y;
    end
    if (cmd.seg_ld) begin
      dx <= 33'(rd_x) - 33'(x0);
      dy <= 33'(rd_y) - 33'(y0);
      dq <= 33'(qx) - 33'(x0);
    end
    if (cmd.set_zero) begin
      res_value  <= y0;
      res_status <= ST_ZERO;
    end
    if (cmd.mul0) begin
      ady  <= dy[32] ? 33'(-dy) : 33'(dy);
      adq  <= dq[32] ? 33'(-dq) : 33'(dq);
      neg  <= dy[32] ^ dq[32];
      dxu  <= dx[31:0];
      prod <= '0;
    end
    // 33x33 product as two partial products: low half in mul1, high half added in div_init
    if (cmd.mul1) prod <= 65'(ady * adq[15:0]);
    if (cmd.div_init) begin
      num     <= prod + 65'((ady * adq[32:16]) << 16) ;
      rem     <= '0;
      div_cnt <= DIV_CW'(DIV_STEPS + 1);
    end
    if (cmd.div_step) begin
      if (div_cnt == DIV_CW'(DIV_STEPS + 1)) begin
        // fold in the rounding term before the first step
        num     <= num + 65'(dxu >> 1);
        div_cnt <= div_cnt - 1'b1;
      end else if (sh >= {1'b0, dxu}) begin
        rem     <= 32'(sh - {1'b0, dxu});
        num     <= {num[63:0], 1'b1};
        div_cnt <= div_cnt - 1'b1;
      end else begin
        rem     <= sh[31:0];
        num     <= {num[63:0], 1'b0};
        div_cnt <= div_cnt - 1'b1;
      end
    end
    if (cmd.fin) begin
      if (res > 37'sh7FFFFFFF) begin
        res_value  <= 32'sh7FFFFFFF;
        res_status <= ST_SAT;
      end else if (res < -37'sh80000000) begin
        res_value  <= 32'sh80000000;
        res_status <= ST_SAT;
      end else begin
        res_value <= res[31:0];
      end
    end
    if (commit) begin
      if (count == '0 || px < lo_x)  lo_x <= px;
      if (count == '0 || px >= hi_x) hi_x <= px;
    end
    if (cmd.out_load) begin
      value_y     <= res_value;
      status      <= res_status;
      lowest_x    <= (count == '0) ? '0 : lo_x;
      highest_x   <= (count == '0) ? '0 : hi_x;
      points_held <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load && req_type == REQ_CLEAR) count <= '0;
      else if (commit)                       count <= count + 1'b1;
      if (cmd.out_load)                      out_valid <= 1'b1;
      else if (out_ready)                    out_valid <= 1'b0;
    end
  end

  assign sts.full     = (count == MAXC);
  assign sts.few      = (count < CW'(2));
  assign sts.empty    = (count == '0);
  assign sts.gt       = gt;
  assign sts.idx_zero = (idx == '0);
  assign sts.bs_done  = (bs_lo == bs_hi);
  assign sts.dx_bad   = dx[32] || (dx == '0);
  assign sts.div_last = (div_cnt == DIV_CW'(1));
  assign sts.out_free = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("point count above table depth");
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    commit |-> count != MAXC)
    else $error("insert committed into a full table");
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result word lost after load");
  a_div_live: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> div_cnt != '0)
    else $error("divider stepped past its last bit");

endmodule

// ----- src/piecewise_linear_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Sorted Q16.16 breakpoint table with clear, insert and evaluate requests.
// ----------------------------------------------------------------------------
// One request word is taken at a time; a new one is accepted while the last
// result word still waits at the output. Clear and rejected requests go
// straight to the output state. Insert reads the stored points from the top
// and moves each larger one up by one place, through the separate read and
// write ports of the breakpoint memories. Evaluate runs a binary search with
// one memory read per probe, two segment reads, a multiply in two partial
// products, a rounding step and a restoring divider that settles one quotient
// bit per cycle over 65 bits.
// The table is not cleared at reset; only entries below the point count are
// ever used.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value_y,
  output logic [2:0]         status,
  output logic signed [31:0] lowest_x,
  output logic signed [31:0] highest_x,
  output logic [CW-1:0]      points_held
);

  cmd_t cmd;
  sts_t sts;

  pli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pli_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .point_x     (point_x),
    .point_y     (point_y),
    .query_x     (query_x),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_y     (value_y),
    .status      (status),
    .lowest_x    (lowest_x),
    .highest_x   (highest_x),
    .points_held (points_held)
  );

endmodule
